>>> hdl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every edge outside reset
`define MMH_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// property checked at every edge, reset included
`define MMH_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");

`endif

>>> hdl/mmh_pkg.sv
// shared types, constants and codes for the murmur64a word hash
// no dependencies
package mmh_pkg;

   localparam int ChunkWidth   = 64;
   localparam int LenWidth     = 8;
   localparam int ReqDataWidth = 72;
   localparam int HashWidth    = 64;
   localparam int HalfWidth    = 32;
   localparam int CsrAddrWidth = 4;
   localparam int CsrDataWidth = 64;
   localparam int MixShift     = 47;

   localparam logic [63:0] MixMul = 64'hc6a4a7935bd1e995;

   // register select bit of the csr address (byte address / 8)
   localparam logic CsrIdxSeed = 1'b0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROUTE,
      ST_LEN,
      ST_K1,
      ST_K2,
      ST_MIXH,
      ST_TAIL,
      ST_FINAL
   } state_type;

   typedef enum logic [1:0] {
      MPH_NONE,
      MPH_P0,
      MPH_P1,
      MPH_P2
   } mul_phase_type;

   typedef enum logic [3:0] {
      WB_NONE,
      WB_LOAD,
      WB_INIT,
      WB_SETK,
      WB_TAIL,
      WB_FOLD,
      WB_K1,
      WB_K2,
      WB_H,
      WB_H_FIN,
      WB_OUT
   } wb_type;

   typedef struct packed {
      mul_phase_type phase;
      wb_type        wb;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic tail_nz;
      logic len_zero;
   } status_type;

endpackage

>>> hdl/mmh_csr.sv
// configuration registers: hash seed behind an apb-style port
// depends on mmh_pkg
module mmh_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [mmh_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [mmh_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic [mmh_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic [mmh_pkg::HashWidth-1:0]    seed
);
   import mmh_pkg::*;

   logic [HashWidth-1:0] seed_ff;
   logic [HashWidth-1:0] seed_in;
   logic                 sel_seed;

   assign sel_seed = (csr_paddr[CsrAddrWidth-1] == CsrIdxSeed);

   always_comb begin
      seed_in = seed_ff;
      if (csr_psel && csr_penable && csr_pwrite && sel_seed) begin
         seed_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else begin
         seed_ff <= seed_in;
      end
   end

   assign csr_prdata = sel_seed ? seed_ff : '0;
   assign seed       = seed_ff;

endmodule

>>> hdl/mmh_ctrl.sv
// controller: sequences load and mixing multiplies of each beat and the output of each word
// depends on mmh_pkg
module mmh_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  mmh_pkg::status_type status,
   output mmh_pkg::cmd_type    cmd
);
   import mmh_pkg::*;

   state_type     state_ff;
   state_type     state_in;
   mul_phase_type phase_ff;
   mul_phase_type phase_in;
   mul_phase_type phase_next;
   logic          start_ff;
   logic          start_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          out_fire;
   logic          stall;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      unique case (phase_ff)
         MPH_P0:   phase_next = MPH_P1;
         MPH_P1:   phase_next = MPH_P2;
         MPH_P2:   phase_next = MPH_P0;
         MPH_NONE: phase_next = MPH_P0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      start_in = start_ff;
      cmd.phase = MPH_NONE;
      cmd.wb = WB_NONE;
      out_fire = 1'b0;
      stall = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.wb = WB_LOAD;
               start_in = 1'b0;
               state_in = start_ff ? ST_LEN : ST_ROUTE;
            end
         end
         ST_ROUTE: begin
            priority if (!status.last || (!status.tail_nz && !status.len_zero)) begin
               cmd.wb = WB_SETK;
               state_in = ST_K1;
            end else if (status.tail_nz) begin
               cmd.wb = WB_TAIL;
               state_in = ST_TAIL;
            end else begin
               cmd.wb = WB_FOLD;
               state_in = ST_FINAL;
            end
         end
         ST_LEN: begin
            cmd.phase = phase_ff;
            if (phase_ff == MPH_P2) begin
               cmd.wb = WB_INIT;
               state_in = ST_ROUTE;
            end
         end
         ST_K1: begin
            cmd.phase = phase_ff;
            if (phase_ff == MPH_P2) begin
               cmd.wb = WB_K1;
               state_in = ST_K2;
            end
         end
         ST_K2: begin
            cmd.phase = phase_ff;
            if (phase_ff == MPH_P2) begin
               cmd.wb = WB_K2;
               state_in = ST_MIXH;
            end
         end
         ST_MIXH: begin
            cmd.phase = phase_ff;
            if (phase_ff == MPH_P2) begin
               if (status.last) begin
                  cmd.wb = WB_H_FIN;
                  state_in = ST_FINAL;
               end else begin
                  cmd.wb = WB_H;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_TAIL: begin
            cmd.phase = phase_ff;
            if (phase_ff == MPH_P2) begin
               cmd.wb = WB_H_FIN;
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            cmd.phase = phase_ff;
            if (phase_ff == MPH_P2) begin
               if (rsp_valid_ff && !rsp_tready) begin
                  // output register still full
                  stall = 1'b1;
               end else begin
                  cmd.wb = WB_OUT;
                  out_fire = 1'b1;
                  start_in = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if ((cmd.phase != MPH_NONE) && !stall) begin
         phase_in = phase_next;
      end
   end

   assign rsp_valid_in = out_fire || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= MPH_P0;
         start_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         start_ff <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hdl/mmh_datapath.sv
// datapath: beat registers, running hash and a shared 32x32 multiplier
// that forms x * mix constant from partial products; depends on mmh_pkg
module mmh_datapath (
   input  logic                             clock,
   input  mmh_pkg::cmd_type                 cmd,
   input  logic [mmh_pkg::ChunkWidth-1:0]   chunk_bytes,
   input  logic [mmh_pkg::LenWidth-1:0]     word_length,
   input  logic                             last_chunk,
   input  logic [mmh_pkg::HashWidth-1:0]    seed,
   output mmh_pkg::status_type              status,
   output logic [mmh_pkg::HashWidth-1:0]    hash_value
);
   import mmh_pkg::*;

   logic [ChunkWidth-1:0]   k_ff;
   logic [ChunkWidth-1:0]   k_in;
   logic [LenWidth-1:0]     len_ff;
   logic [LenWidth-1:0]     len_in;
   logic                    last_ff;
   logic                    last_in;
   logic [HashWidth-1:0]    h_ff;
   logic [HashWidth-1:0]    h_in;
   logic [HashWidth-1:0]    x_ff;
   logic [HashWidth-1:0]    x_in;
   logic [HashWidth-1:0]    acc_ff;
   logic [HashWidth-1:0]    acc_in;
   logic [HashWidth-1:0]    hash_ff;
   logic [HashWidth-1:0]    hash_in;
   logic [HalfWidth-1:0]    mul_a;
   logic [HalfWidth-1:0]    mul_b;
   logic [2*HalfWidth-1:0]  prod;
   logic [HalfWidth-1:0]    res_hi;
   logic [HashWidth-1:0]    mul_res;
   logic [HashWidth-1:0]    res_fold;

   function automatic logic [ChunkWidth-1:0] byte_mask(input logic [2:0] n);
      logic [ChunkWidth-1:0] m;
      m = '0;
      for (int i = 0; i < ChunkWidth / 8; i++) begin
         m[8*i +: 8] = (3'(i) < n) ? 8'hff : 8'h00;
      end
      return m;
   endfunction

   // partial products: lo*lo, then hi*lo and lo*hi into the upper half
   always_comb begin
      mul_a = x_ff[HalfWidth-1:0];
      mul_b = MixMul[HalfWidth-1:0];
      if (cmd.phase == MPH_P1) begin
         mul_a = x_ff[HashWidth-1:HalfWidth];
      end
      if (cmd.phase == MPH_P2) begin
         mul_b = MixMul[HashWidth-1:HalfWidth];
      end
   end

   assign prod     = mul_a * mul_b;
   assign res_hi   = acc_ff[HashWidth-1:HalfWidth] + prod[HalfWidth-1:0];
   assign mul_res  = {res_hi, acc_ff[HalfWidth-1:0]};
   assign res_fold = mul_res ^ (mul_res >> MixShift);

   always_comb begin
      acc_in = acc_ff;
      unique case (cmd.phase)
         MPH_P0:   acc_in = prod;
         MPH_P1:   acc_in = {res_hi, acc_ff[HalfWidth-1:0]};
         MPH_P2:   acc_in = acc_ff;
         MPH_NONE: acc_in = acc_ff;
      endcase
   end

   always_comb begin
      k_in = k_ff;
      len_in = len_ff;
      last_in = last_ff;
      h_in = h_ff;
      x_in = x_ff;
      hash_in = hash_ff;
      unique case (cmd.wb)
         WB_NONE: begin
         end
         WB_LOAD: begin
            k_in = chunk_bytes;
            len_in = word_length;
            last_in = last_chunk;
            x_in = {{(HashWidth-LenWidth){1'b0}}, word_length};
         end
         WB_INIT:  h_in = seed ^ mul_res;
         WB_SETK:  x_in = k_ff;
         WB_TAIL:  x_in = h_ff ^ (k_ff & byte_mask(len_ff[2:0]));
         WB_FOLD:  x_in = h_ff ^ (h_ff >> MixShift);
         WB_K1:    x_in = res_fold;
         WB_K2:    x_in = h_ff ^ mul_res;
         WB_H:     h_in = mul_res;
         WB_H_FIN: x_in = res_fold;
         WB_OUT:   hash_in = res_fold;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      len_ff <= len_in;
      last_ff <= last_in;
      h_ff <= h_in;
      x_ff <= x_in;
      acc_ff <= acc_in;
      hash_ff <= hash_in;
   end

   assign status.last     = last_ff;
   assign status.tail_nz  = |len_ff[2:0];
   assign status.len_zero = (len_ff == '0);
   assign hash_value      = hash_ff;

endmodule

>>> hdl/murmur64a_word_hash.sv
// MurmurHash64A of a byte word fed as little-endian 8-byte beats. Every beat
// carries the word length; tlast marks the final beat, which yields one 64-bit
// hash on the result channel. Each 64-bit multiply by the mix constant runs
// in partial products on one shared 32x32 multiplier, so it sets the rate: a
// middle beat is loaded, routed and mixed by three multiplies; a final beat
// takes tail and final multiplies with a partial tail, three mixing ones and
// the final one with a full last chunk, the final one alone for an empty word;
// a word's first beat adds one for the length times constant start value. The
// next beat is taken while a result waits in the output register. The seed
// register at byte address 0 is read only on the first beat of a word.
module murmur64a_word_hash (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // chunk_bytes [63:0], word_length [71:64]
   input  logic [mmh_pkg::ReqDataWidth-1:0] req_tdata,
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // hash_value [63:0]
   output logic [mmh_pkg::HashWidth-1:0]    rsp_tdata,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [mmh_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [mmh_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic [mmh_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic                             csr_pready
);
   import mmh_pkg::*;

   cmd_type              cmd;
   status_type           status;
   logic [HashWidth-1:0] seed;

   assign csr_pready = 1'b1;

   mmh_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .seed        (seed)
   );

   mmh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mmh_datapath u_datapath (
      .clock       (clock),
      .cmd         (cmd),
      .chunk_bytes (req_tdata[ChunkWidth-1:0]),
      .word_length (req_tdata[ChunkWidth +: LenWidth]),
      .last_chunk  (req_tlast),
      .seed        (seed),
      .status      (status),
      .hash_value  (rsp_tdata)
   );

endmodule

>>> hdl/mmh_checker.sv
// port-level checks for murmur64a_word_hash, bound to the top level
// depends on mmh_pkg and assert_macros.svh
`include "assert_macros.svh"

module mmh_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [mmh_pkg::HashWidth-1:0]    rsp_tdata,
   input logic                             csr_psel,
   input logic                             csr_penable,
   input logic                             csr_pwrite,
   input logic [mmh_pkg::CsrAddrWidth-1:0] csr_paddr,
   input logic [mmh_pkg::CsrDataWidth-1:0] csr_pwdata,
   input logic [mmh_pkg::CsrDataWidth-1:0] csr_prdata
);
   import mmh_pkg::*;

   logic seed_wr;

   assign seed_wr = csr_psel && csr_penable && csr_pwrite
                    && (csr_paddr[CsrAddrWidth-1] == CsrIdxSeed);

   // a stalled result holds
   `MMH_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))

   // reset empties the output register
   `MMH_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_tvalid)

   // every accepted beat makes the block busy in the cycle after it
   `MMH_ASSERT(a_busy_after_beat, clock, reset, req_tvalid && req_tready |=> !req_tready)

   // a result appears exactly as the block returns to idle
   `MMH_ASSERT(a_rsp_on_finish, clock, reset, $rose(rsp_tvalid) |-> req_tready && $past(!req_tready))

   // the seed reads back what was written
   `MMH_ASSERT(a_seed_readback, clock, reset, seed_wr |=> (csr_paddr[CsrAddrWidth-1] != CsrIdxSeed) || (csr_prdata == $past(csr_pwdata)))

endmodule

bind murmur64a_word_hash mmh_checker u_mmh_checker (.*);

>>> dv/testbench.sv
// self-checking testbench for murmur64a_word_hash: words of random length are streamed as
// 8-byte beats under several seeds and idle patterns, and every hash is compared
// with a local predictor; depends on mmh_pkg and the murmur64a_word_hash rtl
module testbench;

   localparam int          TargetBeats  = 750;
   localparam int          CycleLimit   = 400000;
   localparam int          SettleCycles = 40;
   localparam int          HoldCycles   = 300;
   localparam logic [3:0]  SeedAddr     = {mmh_pkg::CsrIdxSeed, 3'b000};
   localparam logic [3:0]  SpareAddr    = {~mmh_pkg::CsrIdxSeed, 3'b000};

   class hash_scoreboard;
      bit [63:0] seed;
      bit [63:0] running;
      bit        in_word;
      bit [63:0] hash_q[$];
      int        beats;
      int        words;
      int        checked;
      int        errors;

      function new();
         seed    = '0;
         running = '0;
         in_word = 1'b0;
      endfunction

      function bit [63:0] mix_chunk(bit [63:0] h, bit [63:0] k);
         k = k * mmh_pkg::MixMul;
         k = k ^ (k >> mmh_pkg::MixShift);
         k = k * mmh_pkg::MixMul;
         h = h ^ k;
         return h * mmh_pkg::MixMul;
      endfunction

      function void note_beat(bit [63:0] chunk, bit [7:0] len, bit last);
         bit [63:0]   h;
         bit [63:0]   mask;
         int unsigned tail;
         beats++;
         if (!in_word) begin
            running = seed ^ ({56'd0, len} * mmh_pkg::MixMul);
         end
         in_word = 1'b1;
         h = running;
         if (!last) begin
            running = mix_chunk(h, chunk);
            return;
         end
         tail = len % 8;
         if (tail != 0) begin
            mask = (64'd1 << (8 * tail)) - 64'd1;
            h    = (h ^ (chunk & mask)) * mmh_pkg::MixMul;
         end else if (len != 0) begin
            h = mix_chunk(h, chunk);
         end
         h = h ^ (h >> mmh_pkg::MixShift);
         h = h * mmh_pkg::MixMul;
         h = h ^ (h >> mmh_pkg::MixShift);
         hash_q.push_back(h);
         running = '0;
         in_word = 1'b0;
         words++;
      endfunction

      function void check_hash(bit [63:0] got);
         bit [63:0] exp_hash;
         if (hash_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected hash beat %h", got);
            return;
         end
         exp_hash = hash_q.pop_front();
         checked++;
         if (got !== exp_hash) begin
            errors++;
            if (errors <= 10) $display("hash mismatch: expected %h, got %h", exp_hash, got);
         end
      endfunction

      function int pending();
         return hash_q.size();
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid;
   logic                             req_tready;
   // chunk_bytes [63:0], word_length [71:64]
   logic [mmh_pkg::ReqDataWidth-1:0] req_tdata;
   logic                             req_tlast;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   // hash_value [63:0]
   logic [mmh_pkg::HashWidth-1:0]    rsp_tdata;
   logic                             csr_psel;
   logic                             csr_penable;
   logic                             csr_pwrite;
   logic [mmh_pkg::CsrAddrWidth-1:0] csr_paddr;
   logic [mmh_pkg::CsrDataWidth-1:0] csr_pwdata;
   logic [mmh_pkg::CsrDataWidth-1:0] csr_prdata;
   logic                             csr_pready;

   hash_scoreboard sb = new();
   int             tx_idle_pct = 0;
   int             rx_idle_pct = 0;
   int             stall_asks  = 0;
   int             stall_seen  = 0;
   int             hold_left   = 0;
   int             cycles      = 0;
   int             seed_count  = 0;
   int             csr_errors  = 0;

   murmur64a_word_hash u_top (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tlast   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   // receiver: random back-pressure plus an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_seen != stall_asks) begin
         stall_seen <= stall_asks;
         hold_left  <= HoldCycles;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_hash(rsp_tdata);
   end

   task automatic csr_access(input bit wr, input logic [3:0] addr, input bit [63:0] wdata,
                             output bit [63:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_seed(input bit [63:0] value);
      bit [63:0] rd;
      csr_access(1'b1, SeedAddr, value, rd);
      sb.seed = value;
      seed_count++;
      csr_access(1'b0, SeedAddr, '0, rd);
      if (rd !== value) begin
         csr_errors++;
         $display("seed readback: expected %h, got %h", value, rd);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   function automatic bit [63:0] pick_chunk();
      case ($urandom_range(15))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic send_beat(input bit [63:0] chunk, input bit [7:0] len, input bit last);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {len, chunk};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_beat(chunk, len, last);
   endtask

   // first beat carries first_len, a later final beat final_len, middle beats mid_len
   task automatic send_word(input int first_len, input int mid_len, input int final_len,
                            input int beats);
      for (int i = 0; i < beats; i++) begin
         if (i == beats - 1)
            send_beat(pick_chunk(), (i == 0) ? first_len[7:0] : final_len[7:0], 1'b1);
         else
            send_beat(pick_chunk(), (i == 0) ? first_len[7:0] : mid_len[7:0], 1'b0);
      end
   endtask

   task automatic send_proper_word(input int len);
      int beats;
      beats = (len + 7) / 8;
      if (beats == 0) beats = 1;
      send_word(len, len, len, beats);
   endtask

   task automatic random_phase(input int tx_pct, input int rx_pct, input int beat_quota,
                               input bit with_hold);
      int start_beats;
      int len;
      bit held;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      start_beats = sb.beats;
      held        = 1'b0;
      while (sb.beats - start_beats < beat_quota) begin
         if (with_hold && !held && sb.beats - start_beats > 40) begin
            stall_asks++;
            held = 1'b1;
         end
         if ($urandom_range(9) == 0) begin
            send_word($urandom_range(255), $urandom_range(255), $urandom_range(255),
                      $urandom_range(1, 5));
         end else begin
            len = ($urandom_range(24) == 0) ? $urandom_range(128, 255) : $urandom_range(40);
            send_proper_word(len);
         end
      end
      wait_drained();
   endtask

   initial begin
      bit [63:0] rd;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_seed('0);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      send_beat('1, 8'd0, 1'b1);
      send_beat({$urandom, $urandom}, 8'd1, 1'b1);
      send_beat('1, 8'd7, 1'b1);
      send_beat('0, 8'd8, 1'b1);
      send_beat('1, 8'd8, 1'b1);
      send_beat('1, 8'd255, 1'b1);
      send_proper_word(9);
      send_proper_word(16);
      // too many beats for the length: extra beats still mix as full chunks
      send_word(3, 3, 3, 3);
      // final beat length differs from the first: full, empty and tail endings
      send_word(20, 20, 8, 3);
      send_word(13, 13, 0, 2);
      send_word(5, 5, 12, 2);
      send_word(128, 64, 71, 2);
      wait_drained();

      set_seed('1);
      random_phase(8, 69, TargetBeats / 3, 1'b1);

      csr_access(1'b1, SpareAddr, {$urandom, $urandom}, rd);
      csr_access(1'b0, SeedAddr, '0, rd);
      if (rd !== sb.seed) begin
         csr_errors++;
         $display("seed changed by write to spare address: %h", rd);
      end
      set_seed({$urandom, $urandom});
      random_phase(69, 8, TargetBeats / 3, 1'b0);

      set_seed(64'h8000_0000_0000_0001);
      random_phase(0, 0, TargetBeats / 3, 1'b1);

      $display("covered %0d words in %0d beats under %0d seeds with three idle patterns",
               sb.words, sb.beats, seed_count);
      $display("%0d hashes checked, %0d mismatches, %0d register errors, %0d left waiting",
               sb.checked, sb.errors, csr_errors, sb.pending());
      if (sb.errors == 0 && csr_errors == 0 && sb.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
